@@ hdl/mbrtu_pkg.sv @@
// Shared types, constants and helpers for the Modbus RTU register slave.
// No dependencies; imported by every module of the block.
package mbrtu_pkg;

  localparam int unsigned HOLDING_COUNT = 16;
  localparam int unsigned INPUT_COUNT   = 16;
  localparam int unsigned FRAME_BYTES   = 256;
  localparam int unsigned FA_W          = $clog2(FRAME_BYTES);
  localparam int unsigned HA_W          = (HOLDING_COUNT > 1) ? $clog2(HOLDING_COUNT) : 1;
  localparam int unsigned IA_W          = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  EXC_FLAG = 8'h80;
  localparam logic [15:0] RD_QTY_MAX = 16'd125;
  localparam logic [15:0] WR_QTY_MAX = 16'd123;

  localparam logic [7:0] FN_RD_HOLD  = 8'h03;
  localparam logic [7:0] FN_RD_INPUT = 8'h04;
  localparam logic [7:0] FN_WR_SINGLE = 8'h06;
  localparam logic [7:0] FN_WR_MULTI = 8'h10;

  localparam logic [7:0] EXC_ILL_FUNC = 8'h01;
  localparam logic [7:0] EXC_ILL_ADDR = 8'h02;
  localparam logic [7:0] EXC_ILL_VAL  = 8'h03;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
  } out_word_t;

  typedef enum logic [4:0] {
    ST_RX,       // take frame bytes
    ST_RD,       // issue store read
    ST_CRC_LD,   // latch store byte into crc
    ST_CRC_BIT,  // one crc bit per cycle
    ST_HDR,      // load header fields, one byte per step
    ST_HDR_WT,
    ST_CHECK,    // decide response
    ST_WM_RD,    // write multiple: read data bytes
    ST_WM_WT,
    ST_WM_WR,
    ST_TX_GEN,   // build next tx byte
    ST_TX_CRC,   // feed it through crc
    ST_TX_OUT,   // present it
    ST_TX_RD,
    ST_TX_RDWT
  } state_t;

  // One step of the reflected CRC-16.
  function automatic logic [15:0] crc_bit(input logic [15:0] c);
    crc_bit = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
  endfunction

endpackage

@@ hdl/mbrtu_crc.sv @@
// Bit-serial CRC-16 unit shared by frame check and response build.
// Depends on mbrtu_pkg.
module mbrtu_crc import mbrtu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        init,
  input  logic        load,
  input  logic [7:0]  data,
  input  logic        step,
  output logic [15:0] crc
);

  logic [15:0] crc_r, crc_nxt;

  // Seed, xor a byte, or shift one bit
  always_comb begin
    crc_nxt = crc_r;
    if (init) begin
      crc_nxt = CRC_INIT;
    end else if (load) begin
      crc_nxt = crc_r ^ {8'h00, data};
    end else if (step) begin
      crc_nxt = crc_bit(crc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  assign crc = crc_r;

endmodule

@@ hdl/modbus_rtu_register_slave_top.sv @@
// Modbus RTU register slave top level: frame store, sequencer, register files.
// Depends on mbrtu_pkg and mbrtu_crc.
// Takes one frame byte per word (one cycle each while receiving). At frame end
// the sequencer re-reads the stored frame and runs each byte but the closing CRC
// pair through the bit-serial CRC unit: a store read, a load, then shifts bit by
// bit. Each response byte is then built, loaded into the same CRC unit, shifted
// bit by bit and shown; bytes echoed from the store are first read back from the
// store, and the two CRC bytes skip the CRC unit. out_stall can hold each byte.
// in_stall is high from the closing byte until the last response word is taken,
// or until the frame is dropped if it gets no response. No clearing pass.
module modbus_rtu_register_slave_top import mbrtu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_data
);

  state_t state_r, state_nxt;

  logic [7:0]  addr_r;
  logic [7:0]  fstore [FRAME_BYTES];
  logic [7:0]  rd_data_r;
  logic [FA_W-1:0] rd_addr;
  logic        rd_en;
  logic [8:0]  cnt_r, cnt_nxt;
  logic        ovf_r, ovf_nxt;
  logic [8:0]  len_r, len_nxt;
  logic [8:0]  idx_r, idx_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [15:0] hreg_r [HOLDING_COUNT];
  logic [15:0] ireg_r [INPUT_COUNT];
  logic [7:0]  b0_r, b0_nxt, fn_r, fn_nxt, b2_r, b2_nxt, b3_r, b3_nxt;
  logic [7:0]  b4_r, b4_nxt, b5_r, b5_nxt, b6_r, b6_nxt, crl_r, crl_nxt;
  logic [7:0]  crh_r, crh_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [2:0]  mode_r, mode_nxt;     // 0 exc, 1 read, 2 echo, 3 write multiple
  logic [7:0]  exc_r, exc_nxt;
  logic [8:0]  tlen_r, tlen_nxt;
  logic [7:0]  tb_r, tb_nxt;
  logic        crc_init, crc_load, crc_step;
  logic [7:0]  crc_data;
  logic [15:0] crc;
  logic        hwe;
  logic [HA_W-1:0] hwa;
  logic [15:0] hwd;
  logic        tx_loaded_r;

  localparam logic [2:0] M_EXC = 3'd0, M_READ = 3'd1, M_ECHO = 3'd2, M_WM = 3'd3;

  wire acc_in  = in_valid && !in_stall;
  wire acc_out = out_valid && !out_stall;
  wire [15:0] start = {b2_r, b3_r};
  wire [15:0] qty   = {b4_r, b5_r};
  wire [16:0] endr  = {1'b0, start} + {1'b0, qty};

  logic crc_load_f, crc_step_f;

  assign in_stall = (state_r != ST_RX);

  mbrtu_crc u_crc (
    .clk(clk), .rst_n(rst_n), .init(crc_init), .load(crc_load_f),
    .data(crc_data), .step(crc_step_f), .crc(crc)
  );

  // Hold the station address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= 8'd1;
    end else if (cfg_we) begin
      addr_r <= cfg_wdata;
    end
  end

  // Frame store: write on receive, registered read for the sequencer
  always_ff @(posedge clk) begin
    if (acc_in && cnt_r < 9'(FRAME_BYTES)) begin
      fstore[cnt_r[FA_W-1:0]] <= in_data.rx_byte;
    end
    if (rd_en) begin
      rd_data_r <= fstore[rd_addr];
    end
  end

  // Register files
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HOLDING_COUNT; i++) hreg_r[i] <= 16'(i);
      for (int i = 0; i < INPUT_COUNT; i++) ireg_r[i] <= 16'(2 * i);
    end else if (hwe) begin
      hreg_r[hwa] <= hwd;
    end
  end

  // Read data for response byte k (k = idx - 3)
  logic [15:0] rv;
  logic [7:0]  ri;
  always_comb begin
    ri = 8'(start) + 8'((idx_r - 9'd3) >> 1);
    if (fn_r == FN_RD_INPUT) begin
      rv = ireg_r[ri[IA_W-1:0]];
    end else begin
      rv = hreg_r[ri[HA_W-1:0]];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RX: begin
        if (acc_in && in_data.frame_end) state_nxt = ST_RD;
      end
      ST_RD: begin
        if (ovf_r || len_r < 9'd4) state_nxt = ST_RX;
        else state_nxt = ST_CRC_LD;
      end
      ST_CRC_LD:  state_nxt = ST_CRC_BIT;
      ST_CRC_BIT: begin
        if (bit_r == 3'd7) begin
          if (idx_r == len_r - 9'd3) state_nxt = ST_HDR;
          else state_nxt = ST_RD;
        end
      end
      ST_HDR:    state_nxt = ST_HDR_WT;
      ST_HDR_WT: begin
        if (idx_r == len_r - 9'd1) state_nxt = ST_CHECK;
        else state_nxt = ST_HDR;
      end
      ST_CHECK: begin
        state_nxt = ST_RX;
        if (b0_r == addr_r && crc == {crh_r, crl_r}) begin
          case (fn_r)
            FN_RD_HOLD, FN_RD_INPUT, FN_WR_SINGLE: begin
              if (len_r >= 9'd8) state_nxt = ST_TX_GEN;
            end
            FN_WR_MULTI: begin
              if (len_r >= 9'd9 && len_r >= 9'd9 + {1'b0, b6_r}) begin
                if (mode_nxt == M_WM) state_nxt = ST_WM_RD;
                else state_nxt = ST_TX_GEN;
              end
            end
            default: state_nxt = ST_TX_GEN;
          endcase
        end
      end
      ST_WM_RD: state_nxt = ST_WM_WT;
      ST_WM_WT: state_nxt = ST_WM_RD;
      ST_WM_WR: state_nxt = ST_TX_GEN;
      ST_TX_GEN: state_nxt = (mode_r == M_ECHO && idx_r < 9'd6 && idx_r >= 9'd2)
                             ? ST_TX_RD : ST_TX_CRC;
      ST_TX_RD:   state_nxt = ST_TX_RDWT;
      ST_TX_RDWT: state_nxt = ST_TX_CRC;
      ST_TX_CRC: begin
        if (idx_r >= tlen_r || bit_r == 3'd7) state_nxt = ST_TX_OUT;
      end
      ST_TX_OUT: begin
        if (acc_out) state_nxt = (idx_r == tlen_r + 9'd1) ? ST_RX : ST_TX_GEN;
      end
      default: state_nxt = ST_RX;
    endcase
    if (state_r == ST_WM_WT && idx_r == 9'd7 + {1'b0, b6_r}) state_nxt = ST_WM_WR;
  end

  // Datapath and outputs
  always_comb begin
    cnt_nxt = cnt_r; ovf_nxt = ovf_r; len_nxt = len_r;
    idx_nxt = idx_r; bit_nxt = bit_r;
    b0_nxt = b0_r; fn_nxt = fn_r; b2_nxt = b2_r; b3_nxt = b3_r;
    b4_nxt = b4_r; b5_nxt = b5_r; b6_nxt = b6_r; crl_nxt = crl_r; crh_nxt = crh_r;
    hi_nxt = hi_r; mode_nxt = mode_r; exc_nxt = exc_r; tlen_nxt = tlen_r; tb_nxt = tb_r;
    crc_init = 1'b0; crc_load = 1'b0; crc_step = 1'b0; crc_data = tb_r;
    rd_en = 1'b0; rd_addr = idx_r[FA_W-1:0];
    hwe = 1'b0; hwa = b3_r[HA_W-1:0]; hwd = {b4_r, b5_r};
    case (state_r)
      ST_RX: begin
        crc_init = 1'b1;
        if (acc_in) begin
          if (cnt_r < 9'(FRAME_BYTES)) cnt_nxt = cnt_r + 9'd1;
          else ovf_nxt = 1'b1;
          if (in_data.frame_end) begin
            len_nxt = (cnt_r < 9'(FRAME_BYTES)) ? cnt_r + 9'd1 : cnt_r;
            ovf_nxt = 1'b0;
            cnt_nxt = '0;
            idx_nxt = '0;
            if (cnt_r >= 9'(FRAME_BYTES)) len_nxt = 9'd0;
          end
        end
      end
      ST_RD: begin
        rd_en = 1'b1;
      end
      ST_CRC_LD: begin
        crc_load = 1'b1; crc_data = rd_data_r; bit_nxt = '0;
        if (idx_r == 9'd0) b0_nxt = rd_data_r;
      end
      ST_CRC_BIT: begin
        crc_step = 1'b1;
        bit_nxt = bit_r + 3'd1;
        if (bit_r == 3'd7) idx_nxt = idx_r + 9'd1;
        if (bit_r == 3'd7 && idx_r == len_r - 9'd3) idx_nxt = 9'd1;
      end
      ST_HDR: rd_en = 1'b1;
      ST_HDR_WT: begin
        case (idx_r)
          9'd1: fn_nxt = rd_data_r;
          9'd2: b2_nxt = rd_data_r;
          9'd3: b3_nxt = rd_data_r;
          9'd4: b4_nxt = rd_data_r;
          9'd5: b5_nxt = rd_data_r;
          9'd6: b6_nxt = rd_data_r;
          default: ;
        endcase
        if (idx_r == len_r - 9'd2) crl_nxt = rd_data_r;
        if (idx_r == len_r - 9'd1) crh_nxt = rd_data_r;
        // skip straight to the CRC bytes past the header
        if (idx_r == 9'd6 || idx_r >= len_r - 9'd2) idx_nxt = idx_r + 9'd1;
        else idx_nxt = idx_r + 9'd1;
        if (idx_r == 9'd6 && len_r > 9'd9) idx_nxt = len_r - 9'd2;
      end
      ST_CHECK: begin
        crc_init = 1'b1;
        idx_nxt = '0;
        mode_nxt = M_EXC; exc_nxt = EXC_ILL_FUNC; tlen_nxt = 9'd3;
        case (fn_r)
          FN_RD_HOLD, FN_RD_INPUT: begin
            if (qty == 16'd0 || qty > RD_QTY_MAX) exc_nxt = EXC_ILL_VAL;
            else if (endr > 17'((fn_r == FN_RD_HOLD) ? HOLDING_COUNT : INPUT_COUNT))
              exc_nxt = EXC_ILL_ADDR;
            else begin
              mode_nxt = M_READ; tlen_nxt = 9'd3 + {qty[7:0], 1'b0};
            end
          end
          FN_WR_SINGLE: begin
            if (start >= 16'(HOLDING_COUNT)) exc_nxt = EXC_ILL_ADDR;
            else begin
              mode_nxt = M_ECHO; tlen_nxt = 9'd6;
              hwe = (state_nxt == ST_TX_GEN);
            end
          end
          FN_WR_MULTI: begin
            if (qty == 16'd0 || qty > WR_QTY_MAX || {8'h00, b6_r} != {qty[14:0], 1'b0})
              exc_nxt = EXC_ILL_VAL;
            else if (endr > 17'(HOLDING_COUNT)) exc_nxt = EXC_ILL_ADDR;
            else begin
              mode_nxt = M_WM; tlen_nxt = 9'd6; idx_nxt = 9'd7;
            end
          end
          default: ;
        endcase
      end
      ST_WM_RD: rd_en = 1'b1;
      ST_WM_WT: begin
        idx_nxt = idx_r + 9'd1;
        // odd index carries the high byte, even index completes the register
        if (idx_r[0]) begin
          hi_nxt = rd_data_r;
        end else begin
          hwe = 1'b1;
          hwa = HA_W'(start + 16'((idx_r - 9'd7) >> 1) - 16'd0);
          hwd = {hi_r, rd_data_r};
        end
      end
      ST_WM_WR: begin
        idx_nxt = '0; mode_nxt = M_ECHO;
      end
      ST_TX_GEN: begin
        bit_nxt = '0;
        if (idx_r == 9'd0) tb_nxt = addr_r;
        else if (idx_r == tlen_r) tb_nxt = crc[7:0];
        else if (idx_r == tlen_r + 9'd1) tb_nxt = crc[15:8];
        else begin
          case (mode_r)
            M_EXC: tb_nxt = (idx_r == 9'd1) ? (fn_r | EXC_FLAG) : exc_r;
            M_READ: begin
              if (idx_r == 9'd1) tb_nxt = fn_r;
              else if (idx_r == 9'd2) tb_nxt = {qty[6:0], 1'b0};
              else tb_nxt = idx_r[0] ? rv[15:8] : rv[7:0];
            end
            default: tb_nxt = fn_r;
          endcase
        end
      end
      ST_TX_RD: rd_en = 1'b1;
      ST_TX_RDWT: tb_nxt = rd_data_r;
      ST_TX_CRC: begin
        // count shifts only once the byte has been xored in
        if (tx_loaded_r) bit_nxt = bit_r + 3'd1;
      end
      ST_TX_OUT: begin
        if (acc_out) idx_nxt = idx_r + 9'd1;
      end
      default: ;
    endcase
  end

  // CRC over response bytes: load on entry, then 8 shifts
  always_ff @(posedge clk) begin
    if (!rst_n) tx_loaded_r <= 1'b0;
    else tx_loaded_r <= (state_r == ST_TX_CRC) && (state_nxt == ST_TX_CRC);
  end

  assign crc_load_f = crc_load || ((state_r == ST_TX_CRC) && idx_r < tlen_r && !tx_loaded_r);
  assign crc_step_f = crc_step || ((state_r == ST_TX_CRC) && idx_r < tlen_r && tx_loaded_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RX; cnt_r <= '0; ovf_r <= 1'b0; len_r <= '0;
      idx_r <= '0; bit_r <= '0; mode_r <= M_EXC; tlen_r <= '0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; ovf_r <= ovf_nxt; len_r <= len_nxt;
      idx_r <= idx_nxt; bit_r <= bit_nxt; mode_r <= mode_nxt; tlen_r <= tlen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b0_r <= b0_nxt; fn_r <= fn_nxt; b2_r <= b2_nxt; b3_r <= b3_nxt;
    b4_r <= b4_nxt; b5_r <= b5_nxt; b6_r <= b6_nxt; crl_r <= crl_nxt; crh_r <= crh_nxt;
    hi_r <= hi_nxt; exc_r <= exc_nxt; tb_r <= tb_nxt;
  end

  assign out_valid        = (state_r == ST_TX_OUT);
  assign out_data.tx_byte = tb_r;
  assign out_data.tx_last = (idx_r == tlen_r + 9'd1);

  // Checks on the sequencer
  a_no_in_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RX) |-> in_stall) else $error("input taken while busy");
  a_out_only_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == ST_TX_OUT)) else $error("stray output");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_out && out_data.tx_last) |=> (state_r == ST_RX)) else $error("no return");

endmodule

@@ tb/modbus_rtu_register_slave_top_tb.sv @@
// Self-checking testbench for the Modbus RTU register slave top level.
// Depends on mbrtu_pkg and the modbus_rtu_register_slave_top RTL only.
`timescale 1ns / 100ps

module modbus_rtu_register_slave_top_tb import mbrtu_pkg::*;;

  typedef logic [7:0] byte_q_t[$];
  typedef enum {ROW_SILENT, ROW_EXC, ROW_MODEL} row_kind_t;
  typedef struct {
    logic [7:0]  fn;
    logic [15:0] a;
    logic [15:0] b;
    int          nbody;
    bit          crc_on;
    row_kind_t   kind;
    logic [7:0]  code;
  } dir_row_t;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 3000;
  localparam int PHASE_WORDS = 50;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  // Shadow state of the slave
  logic [7:0]  shadow_frame [FRAME_BYTES];
  int          shadow_count;
  bit          shadow_ovf;
  logic [15:0] shadow_hold [HOLDING_COUNT];
  logic [15:0] shadow_input [INPUT_COUNT];
  logic [7:0]  shadow_station;

  out_word_t resp_words_due[$];
  int        mismatch_count = 0;
  int        words_sent = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  bit        long_hold_req = 1'b0;
  int        long_hold_left = 0;

  dir_row_t dir_rows [7] = '{
    '{FN_RD_HOLD,   16'd0,  16'd0,     3, 1'b0, ROW_SILENT, 8'h00},
    '{8'h2B,        16'd0,  16'd0,     2, 1'b1, ROW_EXC,    EXC_ILL_FUNC},
    '{FN_RD_HOLD,   16'd0,  16'd0,     6, 1'b1, ROW_EXC,    EXC_ILL_VAL},
    '{FN_WR_SINGLE, 16'd16, 16'hFFFF,  6, 1'b1, ROW_EXC,    EXC_ILL_ADDR},
    '{FN_WR_SINGLE, 16'd15, 16'hFFFF,  6, 1'b1, ROW_MODEL,  8'h00},
    '{FN_RD_INPUT,  16'd0,  16'd16,    6, 1'b1, ROW_MODEL,  8'h00},
    '{FN_RD_HOLD,   16'd0,  16'd16,    6, 1'b1, ROW_MODEL,  8'h00}
  };

  modbus_rtu_register_slave_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [15:0] crc16_calc(byte_q_t q);
    logic [15:0] c;
    c = 16'hFFFF;
    foreach (q[i]) begin
      c ^= {8'h00, q[i]};
      repeat (8) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function automatic byte_q_t with_crc(byte_q_t q);
    logic [15:0] c;
    c = crc16_calc(q);
    q.push_back(c[7:0]);
    q.push_back(c[15:8]);
    return q;
  endfunction

  // Queue a response body plus CRC as expected words
  function automatic void expect_response(byte_q_t body);
    byte_q_t full;
    full = with_crc(body);
    foreach (full[i])
      resp_words_due.push_back('{tx_byte: full[i], tx_last: i == full.size() - 1});
  endfunction

  function automatic void shadow_reset();
    for (int i = 0; i < HOLDING_COUNT; i++) shadow_hold[i] = 16'(i);
    for (int i = 0; i < INPUT_COUNT; i++) shadow_input[i] = 16'(2 * i);
    shadow_count = 0;
    shadow_ovf = 1'b0;
    shadow_station = 8'd1;
  endfunction

  // Advance the shadow slave by one received byte
  function automatic void slave_take_byte(logic [7:0] b, logic last);
    int len;
    bit ovf;
    int limit;
    logic [7:0] fn;
    logic [15:0] p1, p2;
    byte_q_t body;
    byte_q_t rsp;
    if (shadow_count < FRAME_BYTES) begin
      shadow_frame[shadow_count] = b;
      shadow_count++;
    end else begin
      shadow_ovf = 1'b1;
    end
    if (!last) return;
    len = shadow_count;
    ovf = shadow_ovf;
    shadow_count = 0;
    shadow_ovf = 1'b0;
    if (ovf || len < 4 || shadow_frame[0] != shadow_station) return;
    for (int i = 0; i < len - 2; i++) body.push_back(shadow_frame[i]);
    if (crc16_calc(body) != {shadow_frame[len - 1], shadow_frame[len - 2]}) return;
    fn = shadow_frame[1];
    p1 = {shadow_frame[2], shadow_frame[3]};
    p2 = {shadow_frame[4], shadow_frame[5]};
    case (fn)
      FN_RD_HOLD, FN_RD_INPUT: begin
        if (len < 8) return;
        limit = (fn == FN_RD_HOLD) ? HOLDING_COUNT : INPUT_COUNT;
        if (p2 < 1 || p2 > RD_QTY_MAX) begin
          rsp = {shadow_station, fn | EXC_FLAG, EXC_ILL_VAL};
        end else if (int'(p1) + int'(p2) > limit) begin
          rsp = {shadow_station, fn | EXC_FLAG, EXC_ILL_ADDR};
        end else begin
          rsp = {shadow_station, fn, 8'(p2 * 2)};
          for (int i = 0; i < p2; i++) begin
            if (fn == FN_RD_HOLD)
              rsp = {rsp, shadow_hold[p1 + i][15:8], shadow_hold[p1 + i][7:0]};
            else
              rsp = {rsp, shadow_input[p1 + i][15:8], shadow_input[p1 + i][7:0]};
          end
        end
      end
      FN_WR_SINGLE: begin
        if (len < 8) return;
        if (p1 >= HOLDING_COUNT) begin
          rsp = {shadow_station, fn | EXC_FLAG, EXC_ILL_ADDR};
        end else begin
          shadow_hold[p1] = p2;
          rsp = body[0:5];
        end
      end
      FN_WR_MULTI: begin
        if (len < 9 || len < 9 + int'(shadow_frame[6])) return;
        if (p2 < 1 || p2 > WR_QTY_MAX || int'(shadow_frame[6]) != 2 * int'(p2)) begin
          rsp = {shadow_station, fn | EXC_FLAG, EXC_ILL_VAL};
        end else if (int'(p1) + int'(p2) > HOLDING_COUNT) begin
          rsp = {shadow_station, fn | EXC_FLAG, EXC_ILL_ADDR};
        end else begin
          for (int i = 0; i < p2; i++)
            shadow_hold[p1 + i] = {shadow_frame[7 + 2 * i], shadow_frame[8 + 2 * i]};
          rsp = {shadow_station, FN_WR_MULTI, p1[15:8], p1[7:0], p2[15:8], p2[7:0]};
        end
      end
      default: rsp = {shadow_station, fn | EXC_FLAG, EXC_ILL_FUNC};
    endcase
    expect_response(rsp);
  endfunction

  function automatic void slave_take_frame(byte_q_t f);
    foreach (f[i]) slave_take_byte(f[i], i == f.size() - 1);
  endfunction

  function automatic logic [15:0] pick_field();
    logic [15:0] choices [5] = '{16'd0, 16'd123, 16'd124, 16'd125, 16'd126};
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: return choices[$urandom_range(4)];
      default: return 16'($urandom_range(17));
    endcase
  endfunction

  // Mostly well-formed requests, the rest noise and broken frames
  function automatic byte_q_t random_frame();
    logic [7:0] fn_set [4] = '{FN_RD_HOLD, FN_RD_INPUT, FN_WR_SINGLE, FN_WR_MULTI};
    logic [7:0] fn;
    logic [15:0] start, qty;
    int pick, bc;
    byte_q_t f;
    pick = $urandom_range(99);
    if (pick >= 95) begin
      repeat ($urandom_range(1, 12)) f.push_back(8'($urandom));
      if ($urandom_range(1)) f[0] = shadow_station;
      return f;
    end
    if (pick >= 88) begin
      do fn = 8'($urandom);
      while (fn inside {FN_RD_HOLD, FN_RD_INPUT, FN_WR_SINGLE, FN_WR_MULTI});
      f = {shadow_station, fn};
      repeat ($urandom_range(6)) f.push_back(8'($urandom));
      return with_crc(f);
    end
    fn = fn_set[$urandom_range(3)];
    start = pick_field();
    qty = pick_field();
    f = {shadow_station, fn, start[15:8], start[7:0], qty[15:8], qty[7:0]};
    if (fn == FN_WR_MULTI) begin
      if ($urandom_range(7) == 0 || qty > 20) bc = $urandom_range(40);
      else bc = 2 * qty;
      f.push_back(8'(bc));
      repeat (bc) f.push_back(8'($urandom));
      if ($urandom_range(11) == 0) void'(f.pop_back());
    end else if ($urandom_range(15) == 0) begin
      f = f[0:3];
    end
    if (pick >= 70 && pick < 80)
      f[0] = $urandom_range(1) ? 8'd0 : shadow_station ^ 8'($urandom_range(1, 255));
    f = with_crc(f);
    if (pick >= 80) f[$urandom_range(f.size() - 1)] ^= 8'(1 << $urandom_range(7));
    return f;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0h want %0h", what, got, want);
    mismatch_count++;
  endtask

  // Offer each byte of a frame, idling at random between words
  task automatic send_frame(byte_q_t f);
    foreach (f[i]) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data <= '{rx_byte: f[i], frame_end: i == f.size() - 1};
      @(posedge clk);
      while (in_stall) @(posedge clk);
      words_sent++;
    end
  endtask

  // Drop valid and wait until the slave is idle
  task automatic settle();
    in_valid <= 1'b0;
    while (resp_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_station(logic [7:0] addr);
    cfg_we <= 1'b1;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_station = addr;
  endtask

  // Response side: check each taken word, stall at random or on request
  initial begin
    out_word_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (resp_words_due.size() == 0) begin
          report_mismatch("unexpected word", out_data, 0);
        end else begin
          want = resp_words_due.pop_front();
          if (out_data.tx_byte !== want.tx_byte)
            report_mismatch("tx_byte", out_data.tx_byte, want.tx_byte);
          if (out_data.tx_last !== want.tx_last)
            report_mismatch("tx_last", out_data.tx_last, want.tx_last);
        end
      end
      if (long_hold_req) begin
        long_hold_left = 400;
        long_hold_req = 1'b0;
      end
      if (long_hold_left > 0) begin
        long_hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Main sequence
  initial begin
    byte_q_t f;
    byte_q_t body;
    int mark;
    int target;
    shadow_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_station(8'd1);

    // Directed table
    foreach (dir_rows[r]) begin
      body = {shadow_station, dir_rows[r].fn, dir_rows[r].a[15:8], dir_rows[r].a[7:0],
              dir_rows[r].b[15:8], dir_rows[r].b[7:0]};
      f = body[0:dir_rows[r].nbody - 1];
      if (dir_rows[r].crc_on) f = with_crc(f);
      mark = resp_words_due.size();
      slave_take_frame(f);
      if (dir_rows[r].kind != ROW_MODEL) begin
        while (resp_words_due.size() > mark) void'(resp_words_due.pop_back());
        if (dir_rows[r].kind == ROW_EXC)
          expect_response({shadow_station, dir_rows[r].fn | EXC_FLAG, dir_rows[r].code});
      end
      send_frame(f);
    end
    settle();

    // Random phases with different idling and station addresses
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 55 : 0;
      recv_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 24 : 0;
      set_station((ph == 0) ? 8'd247 : (ph == 1) ? 8'($urandom_range(2, 246)) : 8'd1);
      if (ph == 1) begin
        f = {shadow_station, FN_RD_HOLD};
        repeat (FRAME_BYTES) f.push_back(8'($urandom));
        slave_take_frame(f);
        send_frame(f);
      end
      if (ph == 2) long_hold_req = 1'b1;
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) begin
        f = random_frame();
        slave_take_frame(f);
        send_frame(f);
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
